/* src/mbrpt_pkg.sv */
// Shared types and constants of the sector partition table parser.
// No dependencies; imported by mbr_partition_table_parser.
package mbrpt_pkg;

    // Sector layout
    localparam logic [8:0] TABLE_OFS   = 9'h1be;
    localparam logic [8:0] TABLE_END   = 9'h1fd;
    localparam logic [8:0] SIG_LO_POS  = 9'h1fe;
    localparam logic [8:0] SIG_HI_POS  = 9'h1ff;
    localparam int unsigned TABLE_ENTRIES = 4;
    localparam int unsigned TABLE_BYTES   = 64;
    localparam int unsigned TABLE_AW      = $clog2(TABLE_BYTES);

    localparam logic [7:0] SIG_LO_VAL      = 8'h55;
    localparam logic [7:0] SIG_HI_VAL      = 8'haa;
    localparam logic [7:0] TYPE_PROTECTIVE = 8'hee;
    localparam logic [7:0] TYPE_EXTENDED   = 8'h05;
    localparam logic [7:0] FLAG_ACTIVE     = 8'h80;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 152;

    // Record kinds
    localparam logic REC_SLICE   = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BADSIG = 2'd1,
        STATUS_BOGUS  = 2'd2,
        STATUS_LIMIT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DECIDE,
        ST_SUMMARY
    } state_t;

    // Per-byte match against the known bogus table (three empty entries and
    // a fixed fourth entry of size 50000 sectors)
    function automatic logic bogus_byte_ok(input logic [5:0] k, input logic [7:0] b);
        logic ok;
        case (k) inside
            [6'd0:6'd47]:   ok = (b == 8'h00);
            6'd48:          ok = (b == 8'h80);
            6'd50:          ok = (b == 8'h01);
            6'd52:          ok = (b == 8'ha5);
            6'd53:          ok = (b == 8'hff) || (b == 8'hfe);
            6'd54, 6'd55:   ok = (b == 8'hff);
            6'd60:          ok = (b == 8'h50);
            6'd61:          ok = (b == 8'hc3);
            default:        ok = (b == 8'h00);
        endcase
        return ok;
    endfunction

endpackage

/* src/mbr_partition_table_parser.sv */
// Sector partition table parser: byte stream in, slice and summary records out.
// Depends on mbrpt_pkg (types, layout constants, bogus table match).
//
// Usage:
//   s_* channel carries one sector byte per transaction: s_tdata[7:0] is the
//   byte, s_tuser[0] marks the first byte of a sector, s_tuser[1] (with
//   s_tuser[0]) restarts an extended chain. Bytes are taken one per cycle while idle.
//   cfg_we/cfg_wdata select primary (0) or extended chain (1) parsing.
//   m_* channel returns records; tuser is the record kind, tlast marks the
//   summary record that closes each sector.
//   Table bytes are kept in a 64 x 8 memory. After byte 511 the block stops
//   taking bytes and sweeps the memory entry by entry, reading the 16 bytes
//   of an entry and then deciding on it, for all four entries of a primary
//   table or the first two of an extended one, then sends the summary. A bad
//   signature, or a bogus table in primary mode, goes straight to the summary.
//   The next sector's first byte is taken once the summary sits in the output register.
//   If the receiver stalls, the sweep holds in the decision state, and the
//   summary waits, until the output register frees up; no record is dropped.
//   Reset clears position, chain base, slice count, mode and output valid;
//   the table memory needs no clearing.
module mbr_partition_table_parser
    import mbrpt_pkg::*;
#(
    parameter int unsigned MAX_EXT_SLICES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,   // table_mode
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // [7:0] data_byte
    input  logic [IN_USER_W-1:0]  s_tuser,     // [0] sector_start, [1] chain_restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // [4:0] slot_index, [12:5] part_type,
                                               // [54:13] start_bytes, [95:55] length_bytes,
                                               // [97:96] status, [98] chain_next,
                                               // [139:99] next_offset, [145:140] slice_count
    output logic                  m_tuser,     // [0] rec_kind
    output logic                  m_tlast      // last
);

    localparam logic [5:0] MAX_SLICES = 6'(MAX_EXT_SLICES);

    // Table memory
    logic [7:0] ent_mem [TABLE_BYTES];

    // Control state
    state_t         state_reg,      state_next;
    logic [8:0]     pos_reg,        pos_next;
    logic           mode_reg,       mode_next;
    logic [40:0]    ebr_base_reg,   ebr_base_next;
    logic [5:0]     ext_cnt_reg,    ext_cnt_next;
    logic [7:0]     sig_lo_reg,     sig_lo_next;
    logic [7:0]     sig_hi_reg,     sig_hi_next;
    logic           bogus_reg,      bogus_next;
    logic [5:0]     rd_addr_reg,    rd_addr_next;
    logic           issue_reg,      issue_next;
    logic           vld_reg,        vld_next;
    logic [5:0]     idx_reg;
    logic [2:0]     prim_cnt_reg,   prim_cnt_next;
    logic           out_valid_reg,  out_valid_next;

    // Datapath registers
    logic [7:0]     rdata_reg;
    logic [7:0]     flag_reg;
    logic [7:0]     type_reg;
    logic [31:0]    start_reg;
    logic [31:0]    size_reg;
    status_t        sum_status_reg, sum_status_next;
    logic           sum_link_reg,   sum_link_next;
    logic [40:0]    sum_noff_reg,   sum_noff_next;
    logic [5:0]     sum_cnt_reg,    sum_cnt_next;

    // Output record
    logic           o_kind_reg,   o_kind_next;
    logic [4:0]     o_slot_reg,   o_slot_next;
    logic [7:0]     o_type_reg,   o_type_next;
    logic [41:0]    o_start_reg,  o_start_next;
    logic [40:0]    o_len_reg,    o_len_next;
    status_t        o_status_reg, o_status_next;
    logic           o_link_reg,   o_link_next;
    logic [40:0]    o_noff_reg,   o_noff_next;
    logic [5:0]     o_cnt_reg,    o_cnt_next;
    logic           o_last_reg,   o_last_next;

    // Combinational helpers
    logic           accept;
    logic [7:0]     in_byte;
    logic [8:0]     pos_eff;
    logic           in_table;
    logic [5:0]     tbl_addr;
    logic           out_free;
    logic           out_load;
    logic [1:0]     cur_entry;
    logic [40:0]    start_sec_bytes;
    logic [40:0]    size_bytes;
    logic           emit_prim;
    logic           emit_ext;
    logic           emit;
    logic           final_entry;
    logic           link;
    logic           at_limit;

    assign in_byte  = s_tdata[7:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pos_eff  = s_tuser[0] ? 9'd0 : pos_reg;
    assign in_table = (pos_eff >= TABLE_OFS) && (pos_eff <= TABLE_END);
    assign tbl_addr = 6'(pos_eff - TABLE_OFS);
    assign out_free = !out_valid_reg || m_tready;

    assign cur_entry       = idx_reg[5:4];
    assign start_sec_bytes = {start_reg, 9'd0};
    assign size_bytes      = {size_reg, 9'd0};
    assign emit_prim = (type_reg != TYPE_PROTECTIVE)
                    && ((flag_reg == 8'h00) || (flag_reg == FLAG_ACTIVE))
                    && (size_reg != 32'd0);
    assign emit_ext  = (cur_entry == 2'd0) && (flag_reg[6:0] == 7'd0)
                    && (size_reg != 32'd0) && (ext_cnt_reg < MAX_SLICES);
    assign emit        = mode_reg ? emit_ext : emit_prim;
    assign final_entry = mode_reg ? (cur_entry == 2'd1) : (cur_entry == 2'(TABLE_ENTRIES - 1));
    assign link = (flag_reg == 8'h00) && (type_reg == TYPE_EXTENDED) && (size_reg != 32'd0);
    assign at_limit = (ext_cnt_reg >= MAX_SLICES);

    // Store table bytes and read one byte per cycle for the sweep
    always_ff @(posedge clk)
    begin
        if (accept && in_table)
        begin
            ent_mem[tbl_addr] <= in_byte;
        end
        rdata_reg <= ent_mem[rd_addr_reg];
    end

    // Assemble the current entry from swept bytes
    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            case (idx_reg[3:0]) inside
                4'd0:          flag_reg <= rdata_reg;
                4'd4:          type_reg <= rdata_reg;
                [4'd8:4'd11]:  start_reg[{idx_reg[1:0], 3'b000} +: 8] <= rdata_reg;
                [4'd12:4'd15]: size_reg[{idx_reg[1:0], 3'b000} +: 8] <= rdata_reg;
                default:       ;
            endcase
        end
        idx_reg <= rd_addr_reg;
    end

    // Next state, sweep control and record selection
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        mode_next       = mode_reg;
        ebr_base_next   = ebr_base_reg;
        ext_cnt_next    = ext_cnt_reg;
        sig_lo_next     = sig_lo_reg;
        sig_hi_next     = sig_hi_reg;
        bogus_next      = bogus_reg;
        rd_addr_next    = rd_addr_reg;
        issue_next      = 1'b0;
        vld_next        = 1'b0;
        prim_cnt_next   = prim_cnt_reg;
        sum_status_next = sum_status_reg;
        sum_link_next   = sum_link_reg;
        sum_noff_next   = sum_noff_reg;
        sum_cnt_next    = sum_cnt_reg;
        out_load        = 1'b0;
        o_kind_next     = REC_SLICE;
        o_slot_next     = '0;
        o_type_next     = '0;
        o_start_next    = '0;
        o_len_next      = '0;
        o_status_next   = STATUS_OK;
        o_link_next     = 1'b0;
        o_noff_next     = '0;
        o_cnt_next      = '0;
        o_last_next     = 1'b0;

        if (cfg_we)
        begin
            mode_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] && s_tuser[1])
                    begin
                        ebr_base_next = '0;
                        ext_cnt_next  = '0;
                    end
                    if (in_table)
                    begin
                        bogus_next = (tbl_addr == 6'd0) ? bogus_byte_ok(tbl_addr, in_byte)
                                                        : (bogus_reg && bogus_byte_ok(tbl_addr, in_byte));
                    end
                    if (pos_eff == SIG_LO_POS)
                    begin
                        sig_lo_next = in_byte;
                    end
                    pos_next = pos_eff + 9'd1;
                    if (pos_eff == SIG_HI_POS)
                    begin
                        sig_hi_next   = in_byte;
                        sum_link_next = 1'b0;
                        sum_noff_next = '0;
                        prim_cnt_next = '0;
                        if ((sig_lo_reg != SIG_LO_VAL) || (in_byte != SIG_HI_VAL))
                        begin
                            sum_status_next = STATUS_BADSIG;
                            sum_cnt_next    = mode_reg ? ext_cnt_reg : 6'd0;
                            state_next      = ST_SUMMARY;
                        end
                        else if (!mode_reg && bogus_reg)
                        begin
                            sum_status_next = STATUS_BOGUS;
                            sum_cnt_next    = '0;
                            state_next      = ST_SUMMARY;
                        end
                        else
                        begin
                            rd_addr_next = '0;
                            issue_next   = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                // Issue reads through offset 15, then decide once it lands
                vld_next = issue_reg;
                if (issue_reg)
                begin
                    if (rd_addr_reg[3:0] == 4'd15)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        issue_next   = 1'b1;
                        rd_addr_next = rd_addr_reg + 6'd1;
                    end
                end
                if (vld_reg && (idx_reg[3:0] == 4'd15))
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (!emit || out_free)
                begin
                    if (emit)
                    begin
                        out_load     = 1'b1;
                        o_kind_next  = REC_SLICE;
                        o_type_next  = type_reg;
                        o_len_next   = size_bytes;
                        if (mode_reg)
                        begin
                            o_slot_next  = ext_cnt_reg[4:0];
                            o_start_next = 42'(start_sec_bytes) + 42'(ebr_base_reg);
                            ext_cnt_next = ext_cnt_reg + 6'd1;
                        end
                        else
                        begin
                            o_slot_next   = 5'(cur_entry);
                            o_start_next  = 42'(start_sec_bytes);
                            prim_cnt_next = prim_cnt_reg + 3'd1;
                        end
                    end
                    if (!final_entry)
                    begin
                        rd_addr_next = {cur_entry + 2'd1, 4'd0};
                        issue_next   = 1'b1;
                        state_next   = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_SUMMARY;
                        if (!mode_reg)
                        begin
                            sum_status_next = STATUS_OK;
                            sum_link_next   = 1'b0;
                            sum_noff_next   = '0;
                            sum_cnt_next    = 6'(prim_cnt_reg) + 6'(emit);
                        end
                        else if (at_limit)
                        begin
                            sum_status_next = STATUS_LIMIT;
                            sum_link_next   = 1'b0;
                            sum_noff_next   = '0;
                            sum_cnt_next    = ext_cnt_reg;
                        end
                        else
                        begin
                            sum_status_next = STATUS_OK;
                            sum_link_next   = link;
                            sum_noff_next   = link ? start_sec_bytes : 41'd0;
                            sum_cnt_next    = ext_cnt_reg;
                            if (link)
                            begin
                                ebr_base_next = start_sec_bytes;
                            end
                        end
                    end
                end
            end

            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    o_kind_next   = REC_SUMMARY;
                    o_status_next = sum_status_reg;
                    o_link_next   = sum_link_reg;
                    o_noff_next   = sum_noff_reg;
                    o_cnt_next    = sum_cnt_reg;
                    o_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: load a record or drain on handshake
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            mode_reg      <= 1'b0;
            ebr_base_reg  <= '0;
            ext_cnt_reg   <= '0;
            issue_reg     <= 1'b0;
            vld_reg       <= 1'b0;
            prim_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            mode_reg      <= mode_next;
            ebr_base_reg  <= ebr_base_next;
            ext_cnt_reg   <= ext_cnt_next;
            issue_reg     <= issue_next;
            vld_reg       <= vld_next;
            prim_cnt_reg  <= prim_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sig_lo_reg     <= sig_lo_next;
        sig_hi_reg     <= sig_hi_next;
        bogus_reg      <= bogus_next;
        rd_addr_reg    <= rd_addr_next;
        sum_status_reg <= sum_status_next;
        sum_link_reg   <= sum_link_next;
        sum_noff_reg   <= sum_noff_next;
        sum_cnt_reg    <= sum_cnt_next;
        if (out_load)
        begin
            o_kind_reg   <= o_kind_next;
            o_slot_reg   <= o_slot_next;
            o_type_reg   <= o_type_next;
            o_start_reg  <= o_start_next;
            o_len_reg    <= o_len_next;
            o_status_reg <= o_status_next;
            o_link_reg   <= o_link_next;
            o_noff_reg   <= o_noff_next;
            o_cnt_reg    <= o_cnt_next;
            o_last_reg   <= o_last_next;
        end
    end

    // Drive the result stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {6'd0, o_cnt_reg, o_noff_reg, o_link_reg, o_status_reg,
                       o_len_reg, o_start_reg, o_type_reg, o_slot_reg};

    // Checks
    a_issue_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (state_reg == ST_SWEEP))
        else $error("table read issued outside the sweep");

    a_decide_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> (!issue_reg && !vld_reg))
        else $error("entry decision taken with a read still in flight");

    a_ext_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ext_cnt_reg <= MAX_SLICES)
        else $error("extended slice count past its limit");

    a_prim_count: assert property (@(posedge clk) disable iff (!rst_n)
        prim_cnt_reg <= 3'(TABLE_ENTRIES))
        else $error("primary slice count past the entry count");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |=> !(s_tvalid && s_tready && (state_reg == ST_SWEEP)))
        else $error("sector byte taken during the sweep");

endmodule

/* sim/mbr_partition_table_parser_checker.sv */
// Scoreboard for the sector partition table parser: predicts records from the
// accepted byte stream and compares every accepted record against them.
// Depends on mbrpt_pkg for widths, layout constants and the status codes.
module mbr_partition_table_parser_checker
    import mbrpt_pkg::*;
#(
    parameter int unsigned MAX_SLICES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // [7:0] data_byte
    input  logic [IN_USER_W-1:0]  s_tuser,     // [0] sector_start, [1] chain_restart
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,     // [4:0] slot_index ... [145:140] slice_count
    input  logic                  m_tuser,     // [0] rec_kind
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    pending,
    output int                    slice_recs,
    output int                    summary_recs,
    output int                    badsig_recs,
    output int                    bogus_recs,
    output int                    limit_recs,
    output int                    link_recs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [4:0]  slot;
        logic [7:0]  ptype;
        logic [41:0] start;
        logic [40:0] len;
        status_t     status;
        logic        nxt;
        logic [40:0] noff;
        logic [5:0]  cnt;
        logic        last;
    } part_rec_t;

    // Predicted parser state
    logic        chain_mode = 1'b0;
    logic [8:0]  byte_pos   = '0;
    logic [7:0]  table_mem [0:TABLE_BYTES-1];
    logic [7:0]  sig_lo     = '0;
    logic [7:0]  sig_hi     = '0;
    logic [40:0] ebr_base   = '0;
    logic [5:0]  ext_cnt    = '0;

    part_rec_t   expected_recs [$];
    int          errs     = 0;
    int          n_slice  = 0;
    int          n_summ   = 0;
    int          n_badsig = 0;
    int          n_bogus  = 0;
    int          n_limit  = 0;
    int          n_link   = 0;

    initial
    begin
        for (int i = 0; i < TABLE_BYTES; i++)
            table_mem[i] = '0;
    end

    function automatic logic [31:0] table_word(input int ofs);
        return {table_mem[ofs + 3], table_mem[ofs + 2], table_mem[ofs + 1], table_mem[ofs]};
    endfunction

    // Three empty entries and the fixed fourth entry of the known bogus table
    function automatic logic table_is_bogus();
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < 48; i++)
            if (table_mem[i] != 8'h00)
                hit = 1'b0;
        if (table_mem[48] != FLAG_ACTIVE || table_mem[49] != 8'h00 ||
            table_mem[50] != 8'h01 || table_mem[51] != 8'h00 || table_mem[52] != 8'ha5)
            hit = 1'b0;
        if (table_mem[53] != 8'hff && table_mem[53] != 8'hfe)
            hit = 1'b0;
        if (table_mem[54] != 8'hff || table_mem[55] != 8'hff)
            hit = 1'b0;
        if (table_word(56) != 32'd0 || table_word(60) != 32'd50000)
            hit = 1'b0;
        return hit;
    endfunction

    function automatic part_rec_t slice_rec(input logic [4:0] slot, input logic [7:0] ptype,
                                            input logic [41:0] start, input logic [40:0] len);
        part_rec_t r;
        r        = '0;
        r.kind   = REC_SLICE;
        r.slot   = slot;
        r.ptype  = ptype;
        r.start  = start;
        r.len    = len;
        r.status = STATUS_OK;
        return r;
    endfunction

    function automatic part_rec_t summary_rec(input status_t status, input logic nxt,
                                              input logic [40:0] noff, input logic [5:0] cnt);
        part_rec_t r;
        r        = '0;
        r.kind   = REC_SUMMARY;
        r.status = status;
        r.nxt    = nxt;
        r.noff   = noff;
        r.cnt    = cnt;
        r.last   = 1'b1;
        return r;
    endfunction

    // Work out the records released by the last byte of a sector
    task automatic close_sector();
        logic [5:0]  n;
        logic [7:0]  flag;
        logic [7:0]  ptype;
        logic [31:0] size;
        logic        link;
        logic [40:0] nofs;
        n = '0;
        if (sig_lo != SIG_LO_VAL || sig_hi != SIG_HI_VAL)
        begin
            expected_recs.push_back(summary_rec(STATUS_BADSIG, 1'b0, '0,
                                                chain_mode ? ext_cnt : 6'd0));
        end
        else if (!chain_mode)
        begin
            if (table_is_bogus())
            begin
                expected_recs.push_back(summary_rec(STATUS_BOGUS, 1'b0, '0, '0));
            end
            else
            begin
                for (int e = 0; e < TABLE_ENTRIES; e++)
                begin
                    flag  = table_mem[e * 16];
                    ptype = table_mem[e * 16 + 4];
                    size  = table_word(e * 16 + 12);
                    if (ptype != TYPE_PROTECTIVE && (flag == 8'h00 || flag == FLAG_ACTIVE) &&
                        size != 32'd0)
                    begin
                        expected_recs.push_back(slice_rec(5'(e), ptype,
                            {1'b0, table_word(e * 16 + 8), 9'b0}, {size, 9'b0}));
                        n++;
                    end
                end
                expected_recs.push_back(summary_rec(STATUS_OK, 1'b0, '0, n));
            end
        end
        else
        begin
            // Entry 0 is the logical partition, placed at the current chain base
            if ((table_mem[0] & 8'h7f) == 8'h00 && table_word(12) != 32'd0 &&
                ext_cnt < MAX_SLICES)
            begin
                expected_recs.push_back(slice_rec(ext_cnt[4:0], table_mem[4],
                    {1'b0, table_word(8), 9'b0} + {1'b0, ebr_base}, {table_word(12), 9'b0}));
                ext_cnt++;
            end
            if (ext_cnt >= MAX_SLICES)
            begin
                expected_recs.push_back(summary_rec(STATUS_LIMIT, 1'b0, '0, ext_cnt));
            end
            else
            begin
                // Entry 1 links to the next EBR
                link = table_mem[16] == 8'h00 && table_mem[20] == TYPE_EXTENDED &&
                       table_word(28) != 32'd0;
                nofs = link ? {table_word(24), 9'b0} : '0;
                if (link)
                    ebr_base = nofs;
                expected_recs.push_back(summary_rec(STATUS_OK, link, nofs, ext_cnt));
            end
        end
    endtask

    // Store one sector byte and advance the position
    task automatic take_byte(input logic [7:0] b, input logic first, input logic restart);
        if (first)
        begin
            byte_pos = '0;
            if (restart)
            begin
                ebr_base = '0;
                ext_cnt  = '0;
            end
        end
        if (byte_pos >= TABLE_OFS && byte_pos <= TABLE_END)
            table_mem[6'(byte_pos - TABLE_OFS)] = b;
        else if (byte_pos == SIG_LO_POS)
            sig_lo = b;
        else if (byte_pos == SIG_HI_POS)
            sig_hi = b;
        if (byte_pos == SIG_HI_POS)
            close_sector();
        byte_pos = byte_pos + 9'd1;
    endtask

    task automatic note_field(input string what, input logic [41:0] want,
                              input logic [41:0] got);
        if (want !== got)
        begin
            errs++;
            if (errs <= 10)
                $display("ERROR %0t: field %s expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        end
    endtask

    // Compare one accepted record with the oldest prediction
    task automatic compare_record();
        part_rec_t want;
        if (expected_recs.size() == 0)
        begin
            errs++;
            if (errs <= 10)
                $display("ERROR %0t: record with none predicted, tuser %0d tdata 0x%0h",
                         $time, m_tuser, m_tdata);
        end
        else
        begin
            want = expected_recs.pop_front();
            note_field("rec_kind",     42'(want.kind),   42'(m_tuser));
            note_field("slot_index",   42'(want.slot),   42'(m_tdata[4:0]));
            note_field("part_type",    42'(want.ptype),  42'(m_tdata[12:5]));
            note_field("start_bytes",  want.start,       m_tdata[54:13]);
            note_field("length_bytes", 42'(want.len),    42'(m_tdata[95:55]));
            note_field("status",       42'(want.status), 42'(m_tdata[97:96]));
            note_field("chain_next",   42'(want.nxt),    42'(m_tdata[98]));
            note_field("next_offset",  42'(want.noff),   42'(m_tdata[139:99]));
            note_field("slice_count",  42'(want.cnt),    42'(m_tdata[145:140]));
            note_field("last",         42'(want.last),   42'(m_tlast));
            if (want.kind == REC_SLICE)
                n_slice++;
            else
                n_summ++;
            if (want.status == STATUS_BADSIG)
                n_badsig++;
            if (want.status == STATUS_BOGUS)
                n_bogus++;
            if (want.status == STATUS_LIMIT)
                n_limit++;
            if (want.nxt)
                n_link++;
        end
    endtask

    // Sample both channels and the register write at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_mode = 1'b0;
            byte_pos   = '0;
            ebr_base   = '0;
            ext_cnt    = '0;
            expected_recs.delete();
        end
        else
        begin
            if (cfg_we)
                chain_mode = cfg_wdata;
            if (m_tvalid && m_tready)
                compare_record();
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tuser[0], s_tuser[1]);
        end
        pending      <= expected_recs.size();
        fail_count   <= errs;
        slice_recs   <= n_slice;
        summary_recs <= n_summ;
        badsig_recs  <= n_badsig;
        bogus_recs   <= n_bogus;
        limit_recs   <= n_limit;
        link_recs    <= n_link;
    end

endmodule

/* sim/mbr_partition_table_parser_tb.sv */
// Top of the partition table parser testbench: clock, reset, sector stimulus,
// receiver stalls, watchdog and verdict.
// Depends on mbrpt_pkg, mbr_partition_table_parser and its checker module.
module mbr_partition_table_parser_tb
    import mbrpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_EXT     = 32;
    localparam logic        MODE_PRIMARY  = 1'b0;
    localparam logic        MODE_EXTENDED = 1'b1;
    localparam logic [7:0]  TYPE_BSD    = 8'ha5;
    localparam logic [31:0] BOGUS_SIZE  = 32'd50000;
    localparam int          SECTOR_LEN  = 512;
    localparam int          SETTLE_CYCLES = 150;
    localparam int          HOLD_CYCLES = 700;
    localparam int          IDLE_LIMIT  = 5000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int fail_count;
    int pending;
    int slice_recs;
    int summary_recs;
    int badsig_recs;
    int bogus_recs;
    int limit_recs;
    int link_recs;

    logic [7:0] sector_buf [0:SECTOR_LEN-1];
    int         sectors_sent = 0;
    int         burst_left   = 0;
    logic       steady       = 1'b0;
    logic       hold_req     = 1'b0;
    logic       hold_done    = 1'b0;
    int         hold_left    = 0;
    int         stall_style  = 0;
    int         style_left   = 0;
    int         idle_cycles  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    mbr_partition_table_parser #(
        .MAX_EXT_SLICES (MAX_EXT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    mbr_partition_table_parser_checker #(
        .MAX_SLICES (MAX_EXT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .slice_recs   (slice_recs),
        .summary_recs (summary_recs),
        .badsig_recs  (badsig_recs),
        .bogus_recs   (bogus_recs),
        .limit_recs   (limit_recs),
        .link_recs    (link_recs)
    );

    // Receiver: one long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    stall_style = $urandom % 4;
                    style_left  = $urandom_range(50, 300);
                end
                style_left--;
                case (stall_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom % 2);
                    2:       m_tready <= ($urandom % 4 == 0);
                    default: m_tready <= ($urandom % 10 != 0);
                endcase
            end
        end
    end

    // Abort when neither channel nor the register port moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d idle cycles, %0d records outstanding",
                         idle_cycles, pending);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_u32();
        case ($urandom % 5)
            0:       return 32'd0;
            1:       return '1;
            2:       return 32'($urandom_range(1, 4096));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_flag();
        case ($urandom % 4)
            0:       return 8'h00;
            1:       return FLAG_ACTIVE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom % 5)
            0:       return TYPE_PROTECTIVE;
            1:       return TYPE_EXTENDED;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic put_sig(input logic [7:0] lo, input logic [7:0] hi);
        sector_buf[SIG_LO_POS] = lo;
        sector_buf[SIG_HI_POS] = hi;
    endtask

    // Random sector body with a valid signature
    task automatic fill_sector();
        for (int i = 0; i < SECTOR_LEN; i++)
            sector_buf[i] = 8'($urandom);
        put_sig(SIG_LO_VAL, SIG_HI_VAL);
    endtask

    task automatic put_entry(input int e, input logic [7:0] flag, input logic [7:0] ptype,
                             input logic [31:0] first, input logic [31:0] count);
        int ofs;
        ofs = int'(TABLE_OFS) + 16 * e;
        sector_buf[ofs]     = flag;
        sector_buf[ofs + 4] = ptype;
        for (int k = 0; k < 4; k++)
        begin
            sector_buf[ofs + 8 + k]  = first[8 * k +: 8];
            sector_buf[ofs + 12 + k] = count[8 * k +: 8];
        end
    endtask

    // Known bogus table; an end head other than 255 or 254 makes it a near miss
    task automatic put_bogus(input logic [7:0] end_head);
        int ofs;
        ofs = int'(TABLE_OFS);
        for (int i = 0; i < 48; i++)
            sector_buf[ofs + i] = 8'h00;
        put_entry(3, FLAG_ACTIVE, TYPE_BSD, 32'd0, BOGUS_SIZE);
        sector_buf[ofs + 49] = 8'h00;
        sector_buf[ofs + 50] = 8'h01;
        sector_buf[ofs + 51] = 8'h00;
        sector_buf[ofs + 53] = end_head;
        sector_buf[ofs + 54] = 8'hff;
        sector_buf[ofs + 55] = 8'hff;
    endtask

    // Offer one byte in bursts with random gaps, hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic first, input logic restart);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 64);
            gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {restart, first};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Send the first nbytes of the buffer; later bytes carry stray restarts
    task automatic send_sector(input logic first, input logic restart, input int nbytes);
        steady = ($urandom % 4 == 0);
        send_byte(sector_buf[0], first, restart);
        for (int i = 1; i < nbytes; i++)
            send_byte(sector_buf[i], 1'b0, ($urandom % 16 == 0));
        if (nbytes == SECTOR_LEN)
            sectors_sent++;
    endtask

    // Drop valid, wait for every predicted record, then let the sweep settle
    task automatic drain_records();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_records();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random sectors with truncations and sectors that start by position wrap
    task automatic random_run(input logic m, input int sectors, input int restart_odds);
        int   done;
        logic aligned;
        logic first;
        logic restart;
        done    = 0;
        aligned = 1'b1;
        while (done < sectors)
        begin
            fill_sector();
            if (m == MODE_PRIMARY)
            begin
                if ($urandom % 15 == 0)
                    put_bogus(($urandom % 2) ? 8'hff : 8'hfe);
                else
                    for (int e = 0; e < TABLE_ENTRIES; e++)
                        put_entry(e, pick_flag(), pick_type(), pick_u32(),
                                  ($urandom % 5 == 0) ? 32'd0 : pick_u32());
            end
            else
            begin
                put_entry(0, ($urandom % 4 == 0) ? 8'($urandom) :
                             (($urandom % 2) ? FLAG_ACTIVE : 8'h00),
                          8'($urandom), pick_u32(),
                          ($urandom % 10 == 0) ? 32'd0 : pick_u32());
                if ($urandom % 5 != 0)
                    put_entry(1, 8'h00, TYPE_EXTENDED, pick_u32(), pick_u32() | 32'd1);
                else
                    put_entry(1, pick_flag(), pick_type(), pick_u32(), pick_u32());
            end
            if ($urandom % 10 == 0)
                put_sig(8'($urandom), 8'($urandom));
            restart = (restart_odds > 0) && ($urandom % restart_odds == 0);
            first   = !(aligned && $urandom % 6 == 0) || restart;
            if ($urandom % 12 == 0)
            begin
                send_sector(1'b1, restart, $urandom_range(1, SECTOR_LEN - 1));
                aligned = 1'b0;
            end
            else
            begin
                send_sector(first, restart, SECTOR_LEN);
                aligned = 1'b1;
                done++;
            end
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        write_mode(MODE_PRIMARY);

        // Primary: field extremes, protective type and bad flag skipped
        fill_sector();
        put_entry(0, FLAG_ACTIVE, 8'hff, '1, '1);
        put_entry(1, 8'h00, 8'h00, 32'd0, 32'd1);
        put_entry(2, FLAG_ACTIVE, TYPE_PROTECTIVE, 32'd77, 32'd5);
        put_entry(3, 8'h7f, 8'h07, 32'd9, 32'd9);
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        // Position wrap with a stray restart; odd flag and empty size skipped
        fill_sector();
        put_entry(0, 8'h01, 8'h83, 32'd1, 32'd1);
        put_entry(1, 8'h00, 8'h83, 32'd2, 32'd0);
        put_entry(2, 8'h00, TYPE_EXTENDED, 32'h1234_5678, 32'h8000_0000);
        put_entry(3, FLAG_ACTIVE, 8'h0c, '1, 32'h7fff_ffff);
        send_sector(1'b0, 1'b1, SECTOR_LEN);

        // Bad signature in either byte
        fill_sector();
        put_sig(SIG_LO_VAL ^ 8'h01, SIG_HI_VAL);
        send_sector(1'b1, 1'b0, SECTOR_LEN);
        fill_sector();
        put_sig(SIG_LO_VAL, ~SIG_HI_VAL);
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        // Bogus tables and near misses
        fill_sector();
        put_bogus(8'hff);
        send_sector(1'b1, 1'b0, SECTOR_LEN);
        fill_sector();
        put_bogus(8'hfe);
        send_sector(1'b1, 1'b0, SECTOR_LEN);
        fill_sector();
        put_bogus(8'hfd);
        send_sector(1'b1, 1'b0, SECTOR_LEN);
        fill_sector();
        put_bogus(8'hff);
        sector_buf[int'(TABLE_OFS) + 60] = 8'h51;
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        // Empty table, then a truncated sector followed by a full one
        fill_sector();
        for (int e = 0; e < TABLE_ENTRIES; e++)
            put_entry(e, 8'h00, 8'h00, 32'd0, 32'd0);
        send_sector(1'b1, 1'b0, SECTOR_LEN);
        fill_sector();
        send_sector(1'b1, 1'b0, 300);
        fill_sector();
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        write_mode(MODE_EXTENDED);

        // Chain start with a link at the largest offset
        fill_sector();
        put_entry(0, 8'h00, 8'h83, 32'd100, 32'd200);
        put_entry(1, 8'h00, TYPE_EXTENDED, '1, 32'd1);
        send_sector(1'b1, 1'b1, SECTOR_LEN);

        // Largest start on the largest base; active flag on the link ends it
        fill_sector();
        put_entry(0, FLAG_ACTIVE, 8'hff, '1, '1);
        put_entry(1, FLAG_ACTIVE, TYPE_EXTENDED, 32'd5, 32'd5);
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        // No slice for an odd flag, no link for a wrong type
        fill_sector();
        put_entry(0, 8'h01, 8'h83, 32'd5, 32'd5);
        put_entry(1, 8'h00, 8'h0f, 32'd5, 32'd5);
        send_sector(1'b0, 1'b0, SECTOR_LEN);

        // Empty sizes on both entries
        fill_sector();
        put_entry(0, 8'h00, 8'h83, 32'd5, 32'd0);
        put_entry(1, 8'h00, TYPE_EXTENDED, 32'd5, 32'd0);
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        // Bad signature and a bogus table while walking a chain
        fill_sector();
        put_sig(8'h00, 8'h00);
        send_sector(1'b1, 1'b0, SECTOR_LEN);
        fill_sector();
        put_bogus(8'hff);
        send_sector(1'b1, 1'b0, SECTOR_LEN);

        // Restart the chain
        fill_sector();
        put_entry(0, 8'h00, 8'h07, 32'd63, 32'd2048);
        put_entry(1, 8'h00, TYPE_EXTENDED, 32'd4096, 32'd4096);
        send_sector(1'b1, 1'b1, SECTOR_LEN);

        // Random phases; the receiver holds off once early on
        write_mode(MODE_PRIMARY);
        hold_req = 1'b1;
        random_run(MODE_PRIMARY, 14, 0);
        write_mode(MODE_EXTENDED);
        random_run(MODE_EXTENDED, 50, 0);
        write_mode(MODE_PRIMARY);
        random_run(MODE_PRIMARY, 8, 0);
        write_mode(MODE_EXTENDED);
        random_run(MODE_EXTENDED, 12, 4);

        drain_records();
        $display("Covered %0d sectors in both modes: %0d slice and %0d summary records",
                 sectors_sent, slice_recs, summary_recs);
        $display("Summaries with bad signature %0d, bogus table %0d, slice limit %0d, link %0d",
                 badsig_recs, bogus_recs, limit_recs, link_recs);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
